>>> hdl/pnc_pkg.sv
// Shared types and constants for the nearest palette color search block.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package pnc_pkg;

    // Kind of input word, carried on s_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int CHAN_W     = 8;
    localparam int INDEX_W    = 8;
    localparam int SQ_W       = 2 * CHAN_W;
    localparam int DIST_W     = 18;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Largest possible distance: three channels of 255 squared.
    localparam logic [DIST_W-1:0] DIST_MAX  = 18'd195075;
    // Starting bound of a scan; above every real distance, so the first entry scanned always wins.
    localparam logic [DIST_W-1:0] DIST_INIT = '1;

    // Input word layout, entry_index in the lowest bits.
    typedef struct packed {
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [INDEX_W-1:0] entry_index;
    } pnc_in_t;

    // Result word layout, nearest_index in the lowest bits.
    typedef struct packed {
        logic [OUT_DATA_W-INDEX_W-DIST_W-1:0] pad;
        logic [DIST_W-1:0]                    nearest_distance;
        logic [INDEX_W-1:0]                   nearest_index;
    } pnc_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_entry;
        logic load_query;
        logic read_entry;
        logic load_result;
    } pnc_cmd_t;

endpackage

>>> hdl/palette_nearest_color_search.sv
// Nearest palette color search. Palette write words are taken back to back while idle.
// A query word scans the palette with one memory read per cycle through a single
// distance unit, plus a three-stage read/square/compare pipeline and result load.
// The result word becomes valid once the pipeline has drained and the output is free.
// Reset (aresetn low, synchronous) clears control state; palette contents stay undefined.
module palette_nearest_color_search #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic        s_tuser,   // op: 0 writes a palette entry, 1 queries
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // nearest_index[7:0], nearest_distance[25:8], zeros[31:26]
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    pnc_pkg::pnc_cmd_t cmd;
    logic [ADDR_W-1:0] rd_addr;

    pnc_ctrl #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .ADDR_W         (ADDR_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    pnc_datapath #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .ADDR_W         (ADDR_W)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .in_word (pnc_pkg::pnc_in_t'(s_tdata)),
        .out_word(m_tdata)
    );

endmodule

>>> hdl/pnc_datapath.sv
// Datapath of the palette search: palette memory, distance unit and best-match tracker.
// Driven by pnc_ctrl through pnc_pkg::pnc_cmd_t; uses types from pnc_pkg.
module pnc_datapath #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int ADDR_W          = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pnc_pkg::pnc_cmd_t            cmd,
    input  logic [ADDR_W-1:0]            rd_addr,
    input  pnc_pkg::pnc_in_t             in_word,
    output logic [pnc_pkg::OUT_DATA_W-1:0] out_word
);

    localparam int CW = pnc_pkg::CHAN_W;
    localparam int SW = pnc_pkg::SQ_W;
    localparam int DW = pnc_pkg::DIST_W;
    localparam int IW = pnc_pkg::INDEX_W;

    logic [3*CW-1:0] mem [PALETTE_ENTRIES];

    logic              in_range;
    logic [3*CW-1:0]   rdata_reg;
    logic [ADDR_W-1:0] idx1_reg;
    logic              v1_reg;
    logic [CW-1:0]     q_red_reg, q_green_reg, q_blue_reg;
    logic [CW-1:0]     d_red, d_green, d_blue;
    logic [SW-1:0]     sq_red_reg, sq_green_reg, sq_blue_reg;
    logic [ADDR_W-1:0] idx2_reg;
    logic              v2_reg;
    logic [DW-1:0]     dist_sum;
    logic [DW-1:0]     best_dist_reg;
    logic [ADDR_W-1:0] best_idx_reg;
    pnc_pkg::pnc_out_t res_reg;

    // Writes to slots past the end of the palette are dropped.
    assign in_range = {1'b0, in_word.entry_index} < (IW + 1)'(PALETTE_ENTRIES);

    always_ff @(posedge aclk) begin
        if (cmd.write_entry && in_range) begin
            mem[in_word.entry_index[ADDR_W-1:0]] <= {in_word.red, in_word.green, in_word.blue};
        end
        if (cmd.read_entry) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        d_red   = (rdata_reg[3*CW-1:2*CW] >= q_red_reg) ? rdata_reg[3*CW-1:2*CW] - q_red_reg
                                                        : q_red_reg - rdata_reg[3*CW-1:2*CW];
        d_green = (rdata_reg[2*CW-1:CW] >= q_green_reg) ? rdata_reg[2*CW-1:CW] - q_green_reg
                                                        : q_green_reg - rdata_reg[2*CW-1:CW];
        d_blue  = (rdata_reg[CW-1:0] >= q_blue_reg) ? rdata_reg[CW-1:0] - q_blue_reg
                                                    : q_blue_reg - rdata_reg[CW-1:0];
        dist_sum = DW'(sq_red_reg) + DW'(sq_green_reg) + DW'(sq_blue_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.read_entry;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            q_red_reg     <= in_word.red;
            q_green_reg   <= in_word.green;
            q_blue_reg    <= in_word.blue;
            best_dist_reg <= pnc_pkg::DIST_INIT;
            best_idx_reg  <= '0;
        end else if (v2_reg && (dist_sum < best_dist_reg)) begin
            // Strict compare on a downward scan keeps the highest index on ties.
            best_dist_reg <= dist_sum;
            best_idx_reg  <= idx2_reg;
        end
        idx1_reg     <= rd_addr;
        idx2_reg     <= idx1_reg;
        sq_red_reg   <= d_red * d_red;
        sq_green_reg <= d_green * d_green;
        sq_blue_reg  <= d_blue * d_blue;
        if (cmd.load_result) begin
            res_reg.pad              <= '0;
            res_reg.nearest_distance <= best_dist_reg;
            res_reg.nearest_index    <= IW'(best_idx_reg);
        end
    end

    assign out_word = res_reg;

endmodule

>>> hdl/pnc_ctrl.sv
// Controller of the palette search: input handshake, scan address counter and result valid.
// Issues pnc_pkg::pnc_cmd_t commands to pnc_datapath.
module pnc_ctrl #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int ADDR_W          = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output pnc_pkg::pnc_cmd_t cmd,
    output logic [ADDR_W-1:0] rd_addr
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN1 = 3'd2;
    localparam logic [2:0] ST_DRAIN2 = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              in_fire;
    logic              out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign rd_addr  = cnt_reg;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        cmd             = '0;
        cmd.read_entry  = (state_reg == ST_SCAN);
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == pnc_pkg::OP_QUERY) begin
                        cmd.load_query = 1'b1;
                        cnt_next       = ADDR_W'(PALETTE_ENTRIES - 1);
                        state_next     = ST_SCAN;
                    end else begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg - ADDR_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_DONE;
            ST_DONE: begin
                // Wait until the output register is empty or being emptied.
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/pnc_checker.sv
// Port-level checker for the nearest palette color search, bound to the top level.
// Uses constants from pnc_pkg.
module pnc_checker #(
    parameter int PALETTE_ENTRIES = 256
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A result word waiting on the consumer stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // An accepted query word closes the input side as the scan starts.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pnc_pkg::OP_QUERY) |=> !s_tready)
        else $error("input accepted during a scan");

    // A new result only appears at the end of a scan, when input was held off.
    a_result_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result word without a finished scan");

    // Reported index lies in the palette and the distance is reachable.
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:8] <= pnc_pkg::DIST_MAX)
                  && ({1'b0, m_tdata[7:0]} < 9'(PALETTE_ENTRIES)))
        else $error("result word out of range");

endmodule

bind palette_nearest_color_search pnc_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_pnc_checker (.*);
